FILE: rtl/star_peak_detector_3x3_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the star peak detector RTL
// Each expects clk and arst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef STAR_PEAK_DETECTOR_3X3_MACROS_SVH
`define STAR_PEAK_DETECTOR_3X3_MACROS_SVH

// condition holds at every edge out of reset
`define SPD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define SPD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/spd_pkg.sv
// ---------------------------------------------------------------------------
// spd_pkg
// Types and constants of the 3x3 star peak detector.
// ---------------------------------------------------------------------------
package spd_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_STARS  = 1000;
	localparam int PIXEL_BITS = 8;

	localparam int GEOM_W  = 13;                 // width of geometry registers
	localparam int THR_W   = 8;
	localparam int CFG_W   = 13;                 // widest register
	localparam int COORD_W = 12;
	localparam int LINE_AW = $clog2(MAX_WIDTH);  // line store address
	localparam int CNT_W   = 10;                 // star count field
	localparam int MIN_GEOM = 3;

	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;
	localparam int RST_THR    = 200;

	// event queue between front and back
	localparam int Q_DEPTH = 8;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);
	localparam int OCC_W   = $clog2(Q_DEPTH + 3);

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_THRESHOLD    = 2'd2,
		REG_UNUSED       = 2'd3
	} spd_reg_t;

	typedef enum logic {
		KIND_STAR    = 1'b0,
		KIND_SUMMARY = 1'b1
	} spd_kind_t;

	typedef struct packed {
		logic               star;
		logic               frame_end;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} spd_event_t;

endpackage

FILE: rtl/star_peak_detector_3x3.sv
// ---------------------------------------------------------------------------
// star_peak_detector_3x3
// 3x3 local-maximum star detector on a row-major pixel stream.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue: drive pixel and push; a transaction completes on a rising
//   edge with push high and full low. Pixels run row-major over a frame of
//   frame_width x frame_height (each clamped to 3..4096).
//   Result queue: while empty is low the oldest result sits on kind, star_x,
//   star_y, star_count and last; pop high on an edge takes it.
//   Config: cfg_write with cfg_index 0 width, 1 height, 2 threshold; write
//   only while idle. Values apply from the next pixel.
//   Throughput: one pixel per clock while full is low, set by the line
//   store's separate read and write ports and the one-pass window compare.
//   Order: a star result passes stages s1 and s2, the event queue and the
//   output register after the edge that accepts its lower-right neighbour;
//   a summary follows the frame's last pixel likewise, after any star result.
//   Stall: results wait in an 8-entry event queue plus the output register;
//   full rises when the queue cannot absorb the pixels in flight.
//   Reset: geometry 640x480, threshold 200, counters and window cleared.
//   Line store contents are not cleared; no clearing pass is needed.
// ---------------------------------------------------------------------------
module star_peak_detector_3x3 import spd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_write,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// pixel queue
	input  logic                  push,
	output logic                  full,
	input  logic [PIXEL_BITS-1:0] pixel,
	// result queue
	output logic                  empty,
	input  logic                  pop,
	output logic                  kind,
	output logic [COORD_W-1:0]    star_x,
	output logic [COORD_W-1:0]    star_y,
	output logic [CNT_W-1:0]      star_count,
	output logic                  last
);

	// front -> queue -> back
	logic            ev_push, ev_pop, ev_empty;
	spd_event_t      ev_in, ev_head;
	logic [Q_CW-1:0] ev_count;

	// front: counters, line store, window, peak test
	spd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.pixel      (pixel),
		.full       (full),
		.fifo_count (ev_count),
		.ev_push    (ev_push),
		.ev         (ev_in)
	);

	// decouples the pixel pipeline from result back-pressure
	spd_event_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ev_push),
		.din    (ev_in),
		.pop    (ev_pop),
		.dout   (ev_head),
		.empty  (ev_empty),
		.count  (ev_count)
	);

	// back: star limit, summary, output register
	spd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev_head    (ev_head),
		.ev_empty   (ev_empty),
		.ev_pop     (ev_pop),
		.pop        (pop),
		.empty      (empty),
		.kind       (kind),
		.star_x     (star_x),
		.star_y     (star_y),
		.star_count (star_count),
		.last       (last)
	);

endmodule

FILE: rtl/spd_front.sv
// ---------------------------------------------------------------------------
// spd_front
// Pixel intake: geometry registers, position counters, line store,
// 3x3 window and local-maximum test. Emits one event per pixel that is a
// star candidate, ends the frame, or both.
// ---------------------------------------------------------------------------
`include "star_peak_detector_3x3_macros.svh"

module spd_front import spd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  push,
	input  logic [PIXEL_BITS-1:0] pixel,
	output logic                  full,
	input  logic [Q_CW-1:0]       fifo_count,
	output logic                  ev_push,
	output spd_event_t            ev
);

	logic [GEOM_W-1:0]     width_q, height_q;
	logic [THR_W-1:0]      thr_q;
	logic [GEOM_W-1:0]     w_eff, h_eff;
	logic [LINE_AW-1:0]    c_q;
	logic [COORD_W-1:0]    r_q;
	logic                  accept, row_end, frame_end, interior;
	logic [OCC_W-1:0]      occ;

	logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
	logic [2*PIXEL_BITS-1:0] rd_s1;

	logic                  valid_s1, valid_s2;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [LINE_AW-1:0]    c_s1, c_s2;
	logic [COORD_W-1:0]    r_s1, r_s2;
	logic                  interior_s1, interior_s2;
	logic                  frame_end_s1, frame_end_s2;
	logic [PIXEL_BITS-1:0] win_q [9];
	logic                  is_peak;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= GEOM_W'(RST_WIDTH);
			height_q <= GEOM_W'(RST_HEIGHT);
			thr_q    <= THR_W'(RST_THR);
		end else if (cfg_write) begin
			case (spd_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  width_q  <= cfg_data[GEOM_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[GEOM_W-1:0];
				REG_THRESHOLD:    thr_q    <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < GEOM_W'(MIN_GEOM))       w_eff = GEOM_W'(MIN_GEOM);
		else if (width_q > GEOM_W'(MAX_WIDTH)) w_eff = GEOM_W'(MAX_WIDTH);
		else                                   w_eff = width_q;
		if (height_q < GEOM_W'(MIN_GEOM))        h_eff = GEOM_W'(MIN_GEOM);
		else if (height_q > GEOM_W'(MAX_HEIGHT)) h_eff = GEOM_W'(MAX_HEIGHT);
		else                                     h_eff = height_q;
	end

	// every in-flight item may still produce one event
	assign occ    = OCC_W'(fifo_count) + OCC_W'(valid_s1) + OCC_W'(valid_s2);
	assign full   = (occ >= OCC_W'(Q_DEPTH));
	assign accept = push && !full;

	assign row_end   = (GEOM_W'(c_q) + GEOM_W'(1)) >= w_eff;
	assign frame_end = row_end && ((GEOM_W'(r_q) + GEOM_W'(1)) >= h_eff);
	assign interior  = (c_q >= LINE_AW'(2)) && (GEOM_W'(c_q) < w_eff) &&
	                   (r_q >= COORD_W'(2)) && (GEOM_W'(r_q) < h_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q      <= '0;
			r_q      <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (accept) begin
				if (frame_end) begin
					c_q <= '0;
					r_q <= '0;
				end else if (row_end) begin
					c_q <= '0;
					r_q <= r_q + COORD_W'(1);
				end else begin
					c_q <= c_q + LINE_AW'(1);
				end
			end
		end
	end

	// line store: word = {upper row, middle row} at one column
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= line_mem[c_q];
		end
		if (valid_s1) begin
			line_mem[c_s1] <= {rd_s1[PIXEL_BITS-1:0], pix_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= pixel;
			c_s1         <= c_q;
			r_s1         <= r_q;
			interior_s1  <= interior;
			frame_end_s1 <= frame_end;
		end
		if (valid_s1) begin
			c_s2         <= c_s1;
			r_s2         <= r_s1;
			interior_s2  <= interior_s1;
			frame_end_s2 <= frame_end_s1;
		end
	end

	// window shifts left, new column enters on the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i*3]   <= win_q[i*3+1];
				win_q[i*3+1] <= win_q[i*3+2];
			end
			win_q[2] <= rd_s1[2*PIXEL_BITS-1:PIXEL_BITS];
			win_q[5] <= rd_s1[PIXEL_BITS-1:0];
			win_q[8] <= pix_s1;
		end
	end

	always_comb begin
		is_peak = (win_q[4] > thr_q);
		for (int i = 0; i < 9; i++) begin
			if (i != 4 && !(win_q[4] > win_q[i])) is_peak = 1'b0;
		end
	end

	assign ev_push      = valid_s2 && ((is_peak && interior_s2) || frame_end_s2);
	assign ev.star      = is_peak && interior_s2;
	assign ev.frame_end = frame_end_s2;
	assign ev.x         = COORD_W'(c_s2) - COORD_W'(1);
	assign ev.y         = r_s2 - COORD_W'(1);

	`SPD_ASSERT_ALWAYS(a_occ_bound, occ <= OCC_W'(Q_DEPTH), "event queue over-committed")
	`SPD_ASSERT_NEXT(a_frame_wrap, accept && frame_end, c_q == '0 && r_q == '0,
		"position not cleared at frame end")

endmodule

FILE: rtl/spd_event_fifo.sv
// ---------------------------------------------------------------------------
// spd_event_fifo
// Short queue of events between the front and the back.
// ---------------------------------------------------------------------------
module spd_event_fifo import spd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  spd_event_t      din,
	input  logic            pop,
	output spd_event_t      dout,
	output logic            empty,
	output logic [Q_CW-1:0] count
);

	spd_event_t       mem_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_q, rd_q;
	logic [Q_CW-1:0]  count_q;
	logic             do_pop;

	assign empty  = (count_q == '0);
	assign do_pop = pop && !empty;
	assign dout   = mem_q[rd_q];
	assign count  = count_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)   wr_q <= wr_q + Q_AW'(1);
			if (do_pop) rd_q <= rd_q + Q_AW'(1);
			case ({push, do_pop})
				2'b10:   count_q <= count_q + Q_CW'(1);
				2'b01:   count_q <= count_q - Q_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/spd_back.sv
// ---------------------------------------------------------------------------
// spd_back
// Turns events into results: star count with saturation, star records and
// the end-of-frame summary, held in an output register.
// ---------------------------------------------------------------------------
`include "star_peak_detector_3x3_macros.svh"

module spd_back import spd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  spd_event_t         ev_head,
	input  logic               ev_empty,
	output logic               ev_pop,
	input  logic               pop,
	output logic               empty,
	output logic               kind,
	output logic [COORD_W-1:0] star_x,
	output logic [COORD_W-1:0] star_y,
	output logic [CNT_W-1:0]   star_count,
	output logic               last
);

	logic               out_valid_q, pend_q;
	logic [CNT_W-1:0]   found_q;
	spd_kind_t          out_kind_q;
	logic [COORD_W-1:0] out_x_q, out_y_q;
	logic [CNT_W-1:0]   out_cnt_q;
	logic               out_last_q;

	logic               load, star_ok, emit;
	logic               valid_d, pend_d;
	logic [CNT_W-1:0]   found_d, cnt_d;
	spd_kind_t          kind_d;
	logic [COORD_W-1:0] x_d, y_d;
	logic               last_d;

	assign load    = !out_valid_q || pop;
	assign ev_pop  = load && !pend_q && !ev_empty;
	assign star_ok = ev_head.star && (found_q < CNT_W'(MAX_STARS));

	always_comb begin
		valid_d = out_valid_q;
		pend_d  = pend_q;
		found_d = found_q;
		emit    = 1'b0;
		kind_d  = KIND_SUMMARY;
		x_d     = '0;
		y_d     = '0;
		cnt_d   = found_q;
		last_d  = 1'b1;
		if (load) begin
			valid_d = 1'b0;
			if (pend_q) begin
				// summary that follows a star on the last pixel
				emit    = 1'b1;
				pend_d  = 1'b0;
				found_d = '0;
			end else if (!ev_empty) begin
				if (star_ok) begin
					emit    = 1'b1;
					kind_d  = KIND_STAR;
					x_d     = ev_head.x;
					y_d     = ev_head.y;
					found_d = found_q + CNT_W'(1);
					cnt_d   = found_q + CNT_W'(1);
					last_d  = !ev_head.frame_end;
					pend_d  = ev_head.frame_end;
				end else if (ev_head.frame_end) begin
					emit    = 1'b1;
					found_d = '0;
				end
			end
			if (emit) valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			found_q     <= '0;
		end else begin
			out_valid_q <= valid_d;
			pend_q      <= pend_d;
			found_q     <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= kind_d;
			out_x_q    <= x_d;
			out_y_q    <= y_d;
			out_cnt_q  <= cnt_d;
			out_last_q <= last_d;
		end
	end

	assign empty      = !out_valid_q;
	assign kind       = out_kind_q;
	assign star_x     = out_x_q;
	assign star_y     = out_y_q;
	assign star_count = out_cnt_q;
	assign last       = out_last_q;

	`SPD_ASSERT_IMPL(a_pend_shown, pend_q, out_valid_q, "pending summary without a shown star")
	`SPD_ASSERT_ALWAYS(a_found_sat, found_q <= CNT_W'(MAX_STARS), "star count above limit")
	`SPD_ASSERT_IMPL(a_summary_clears, out_valid_q && out_kind_q == KIND_SUMMARY,
		found_q == '0, "count not cleared behind a summary")

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - star peak detector 3x3 testbench
// Streams pixel frames into the detector through its input queue and checks
// every star and end-of-frame report against an in-bench line-buffer model.
// Covers directed 3x3 frames, geometry changes mid-frame, random frames
// under several idle mixes, and a long output stall that fills the block.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spd_pkg::*;

	localparam int CLK_HALF        = 6;
	localparam int RESET_CYCLES    = 7;
	localparam int SETTLE_CYCLES   = 10;   // covers the report latency
	localparam int HOLD_OFF_CYCLES = 300;  // long receiver stall to fill the block
	localparam int QUIET_LIMIT     = 2000; // cycles with no transaction at all
	localparam int SECTION_PIXELS  = 280;  // random pixels per idle mix
	localparam int GRID_SIZE       = 18;   // rows and columns of the stall frame

	// what a report looks like on the result queue, in port order
	typedef struct packed {
		spd_kind_t          kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [CNT_W-1:0]   count;
		logic               last;
	} star_report_t;

	// pixel content styles for generated frames
	typedef enum int {
		FILL_NOISE,
		FILL_SPARSE,
		FILL_TIES,
		FILL_GRID
	} fill_t;

	// DUT connections, all known from time zero
	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_write  = 1'b0;
	spd_reg_t              cfg_index  = REG_FRAME_WIDTH;
	logic [CFG_W-1:0]      cfg_data   = '0;
	logic                  push       = 1'b0;
	logic                  full;
	logic [PIXEL_BITS-1:0] pixel      = '0;
	logic                  empty;
	logic                  pop        = 1'b0;
	logic                  kind;
	logic [COORD_W-1:0]    star_x;
	logic [COORD_W-1:0]    star_y;
	logic [CNT_W-1:0]      star_count;
	logic                  last;

	// stimulus and scoreboard storage
	logic [PIXEL_BITS-1:0] pending_pixels[$];
	star_report_t          predicted_reports[$];
	int unsigned           mismatch_count = 0;
	int unsigned           quiet_cycles   = 0;

	// idle mix, changed by the sequence between sections
	int unsigned send_idle_pct = 29;
	int unsigned recv_idle_pct = 59;

	// receiver hold-off: sequence bumps the request count, monitor serves it
	int unsigned hold_requests = 0;
	int unsigned hold_served   = 0;
	int unsigned hold_left     = 0;

	// detector shadow: registers, line stores, window and position counters
	logic [CFG_W-1:0]      width_reg  = CFG_W'(RST_WIDTH);
	logic [CFG_W-1:0]      height_reg = CFG_W'(RST_HEIGHT);
	logic [THR_W-1:0]      thr_reg    = THR_W'(RST_THR);
	logic [PIXEL_BITS-1:0] upper_row[MAX_WIDTH]  = '{default: '0};
	logic [PIXEL_BITS-1:0] middle_row[MAX_WIDTH] = '{default: '0};
	logic [PIXEL_BITS-1:0] win[9] = '{default: '0};
	int                    col_pos = 0;
	int                    row_pos = 0;
	int                    found   = 0;

	star_peak_detector_3x3 dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.pixel      (pixel),
		.empty      (empty),
		.pop        (pop),
		.kind       (kind),
		.star_x     (star_x),
		.star_y     (star_y),
		.star_count (star_count),
		.last       (last)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// geometry registers saturate into MIN_GEOM..hi when used
	function automatic int geom_clamp(input logic [CFG_W-1:0] v, input int hi);
		if (v < MIN_GEOM)
			return MIN_GEOM;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	// One accepted pixel through the shadow detector. Appends the star report
	// (if the window it completes holds a strict local maximum above threshold,
	// star limit allowing) and any frame-end summary to the expected reports.
	function automatic void advance_star_window(input logic [PIXEL_BITS-1:0] px);
		int                    w;
		int                    h;
		int                    c;
		int                    r;
		logic [PIXEL_BITS-1:0] above;
		logic [PIXEL_BITS-1:0] beside;
		logic [PIXEL_BITS-1:0] ctr;
		logic                  row_end;
		logic                  frame_end;
		logic                  peak;
		w = geom_clamp(width_reg, MAX_WIDTH);
		h = geom_clamp(height_reg, MAX_HEIGHT);
		c = col_pos;
		r = row_pos;
		// line stores: column c moves up one row and takes the new pixel
		above = upper_row[c];
		beside = middle_row[c];
		upper_row[c] = beside;
		middle_row[c] = px;
		// window slides left, new column enters on the right
		for (int i = 0; i < 3; i++) begin
			win[i * 3] = win[i * 3 + 1];
			win[i * 3 + 1] = win[i * 3 + 2];
		end
		win[2] = above;
		win[5] = beside;
		win[8] = px;
		// current geometry decides row and frame end, even after a mid-frame change
		row_end = (c + 1 >= w);
		frame_end = row_end && (r + 1 >= h);
		if (c >= 2 && c < w && r >= 2 && r < h) begin
			ctr = win[4];
			peak = ctr > thr_reg;
			for (int i = 0; i < 9; i++)
				if (i != 4 && !(ctr > win[i]))
					peak = 1'b0;
			// past the star limit, stars are dropped silently
			if (peak && found < MAX_STARS) begin
				found++;
				predicted_reports.push_back(star_report_t'{KIND_STAR, COORD_W'(c - 1),
					COORD_W'(r - 1), CNT_W'(found), !frame_end});
			end
		end
		if (frame_end) begin
			predicted_reports.push_back(star_report_t'{KIND_SUMMARY, '0, '0,
				CNT_W'(found), 1'b1});
			col_pos = 0;
			row_pos = 0;
			found = 0;
		end else if (row_end) begin
			col_pos = 0;
			row_pos = (r + 1) & 12'hFFF;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	// pixels still needed to close the frame under the current geometry
	function automatic int pixels_to_frame_end();
		int   c;
		int   r;
		int   w;
		int   h;
		int   n;
		logic row_done;
		logic frame_done;
		c = col_pos;
		r = row_pos;
		w = geom_clamp(width_reg, MAX_WIDTH);
		h = geom_clamp(height_reg, MAX_HEIGHT);
		n = 0;
		do begin
			n++;
			row_done = (c + 1 >= w);
			frame_done = row_done && (r + 1 >= h);
			if (row_done) begin
				c = 0;
				r++;
			end else begin
				c++;
			end
		end while (!frame_done);
		return n;
	endfunction

	function automatic logic [PIXEL_BITS-1:0] make_pixel(input fill_t fill, input int x,
			input int y);
		case (fill)
			FILL_SPARSE: begin
				// dim background with scattered bright spots
				if ($urandom_range(7) == 0)
					return PIXEL_BITS'($urandom_range(255, 100));
				return PIXEL_BITS'($urandom_range(40));
			end
			FILL_TIES:
				return PIXEL_BITS'($urandom_range(2));
			FILL_GRID: begin
				// a peak on every odd/odd site, strictly above all its neighbours
				if (x % 2 == 1 && y % 2 == 1)
					return PIXEL_BITS'($urandom_range(255, 200));
				return PIXEL_BITS'($urandom_range(150));
			end
			default:
				return PIXEL_BITS'($urandom_range(255));
		endcase
	endfunction

	task automatic add_pixels(input fill_t fill, input int count, input int row_len);
		for (int i = 0; i < count; i++)
			pending_pixels.push_back(make_pixel(fill, i % row_len, i / row_len));
	endtask

	// 3x3 frame: all 'around' except the centre, and optionally one neighbour
	// that ties with the centre
	task automatic add_window(input logic [PIXEL_BITS-1:0] center,
			input logic [PIXEL_BITS-1:0] around, input int tie_pos);
		for (int i = 0; i < 9; i++)
			pending_pixels.push_back((i == 4 || i == tie_pos) ? center : around);
	endtask

	// one register write transaction; the shadow copy follows at the write edge
	task automatic write_reg(input spd_reg_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH:  width_reg = val;
			REG_FRAME_HEIGHT: height_reg = val;
			REG_THRESHOLD:    thr_reg = val[THR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input logic [THR_W-1:0] thr);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_THRESHOLD, CFG_W'(thr));
		@(negedge clk);
	endtask

	// Idle means: nothing queued, nothing offered, every report in. A pixel can
	// leave no report, so a few more cycles let the pipeline drain.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_pixels.size() != 0 || push || predicted_reports.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Random frames until the pixel budget is spent. Geometry is mostly small,
	// with occasional out-of-range register values that clamp to 3 and a few
	// wider rows. One to three frames share each setting, and only one when the
	// budget would otherwise be overrun.
	task automatic run_random_frames(input int pixel_budget);
		int               queued;
		int               frames;
		int               w_eff;
		int               h_eff;
		logic [CFG_W-1:0] w_reg;
		logic [CFG_W-1:0] h_reg;
		logic [THR_W-1:0] thr;
		fill_t            fill;
		queued = 0;
		while (queued < pixel_budget) begin
			case ($urandom_range(9))
				0:       w_reg = CFG_W'($urandom_range(2));
				1:       w_reg = CFG_W'($urandom_range(80, 25));
				default: w_reg = CFG_W'($urandom_range(24, 3));
			endcase
			if ($urandom_range(7) == 0)
				h_reg = CFG_W'($urandom_range(2));
			else
				h_reg = CFG_W'($urandom_range(10, 3));
			case ($urandom_range(9))
				0:       thr = '1;
				1, 2, 3: thr = THR_W'($urandom_range(255));
				default: thr = THR_W'($urandom_range(60));
			endcase
			fill = fill_t'($urandom_range(FILL_TIES));
			frames = $urandom_range(3, 1);
			w_eff = geom_clamp(w_reg, MAX_WIDTH);
			h_eff = geom_clamp(h_reg, MAX_HEIGHT);
			if (queued + frames * w_eff * h_eff > pixel_budget)
				frames = 1;
			wait_idle();
			load_geometry(w_reg, h_reg, thr);
			repeat (frames)
				add_pixels(fill, w_eff * h_eff, w_eff);
			queued += frames * w_eff * h_eff;
		end
	endtask

	// Driver: offers the next queued pixel unless idling. An offered
	// transaction that meets full stays on the port unchanged until taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && full) begin
				// still waiting for the block to take this pixel
			end else begin
				if (push)
					advance_star_window(pixel);
				if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					push <= 1'b1;
					pixel <= pending_pixels.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each taken report against the oldest expected one, and
	// decides pop for the next edge (random idling or a requested hold-off).
	always @(posedge clk) begin
		star_report_t got;
		star_report_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				got = {kind, star_x, star_y, star_count, last};
				if (predicted_reports.size() == 0) begin
					$display("%0t tb: unexpected report kind=%0d x=%0d y=%0d cnt=%0d last=%0d",
						$time, got.kind, got.x, got.y, got.count, got.last);
					mismatch_count++;
				end else begin
					want = predicted_reports.pop_front();
					if (got !== want) begin
						$display("%0t tb: report mismatch exp kind=%0d x=%0d y=%0d cnt=%0d last=%0d",
							$time, want.kind, want.x, want.y, want.count, want.last);
						$display("%0t tb:                 got kind=%0d x=%0d y=%0d cnt=%0d last=%0d",
							$time, got.kind, got.x, got.y, got.count, got.last);
						mismatch_count++;
					end
				end
			end
			if (hold_left != 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = HOLD_OFF_CYCLES;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: any transaction on either side resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t tb: watchdog, no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("tb: done, errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed 3x3 frames. Threshold is still at its reset value here:
		// a centre just above it with equal neighbours is a star found on the
		// last pixel (star report, then summary); a bright centre tied with
		// its lower-right neighbour is not.
		write_reg(REG_FRAME_WIDTH, CFG_W'(3));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
		@(negedge clk);
		add_window(8'd201, 8'd200, -1);
		add_window(8'd255, 8'd0, 8);
		wait_idle();
		// zero threshold; a write to the spare index must change nothing
		write_reg(REG_THRESHOLD, CFG_W'(0));
		write_reg(REG_UNUSED, '1);
		@(negedge clk);
		add_window(8'd1, 8'd0, -1);

		// Geometry change mid-frame: 10x8 frame, narrow to 6 in row 2, then
		// widen back to 10 and cut the height to 5 while in row 4, which
		// makes row 4 the last one. Columns 6..9 were written in rows 0 and 1.
		wait_idle();
		load_geometry(CFG_W'(10), CFG_W'(8), THR_W'(30));
		add_pixels(FILL_SPARSE, 25, 10);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, CFG_W'(6));
		@(negedge clk);
		add_pixels(FILL_SPARSE, 8, 6);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, CFG_W'(10));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(5));
		@(negedge clk);
		add_pixels(FILL_NOISE, pixels_to_frame_end(), 10);

		// random frames under three idle mixes
		run_random_frames(SECTION_PIXELS);
		wait_idle();
		send_idle_pct = 59;
		recv_idle_pct = 29;
		run_random_frames(SECTION_PIXELS);
		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_frames(SECTION_PIXELS);

		// Long output stall: the grid frame has a peak on every odd/odd site.
		// The receiver holds off at the start while the sender keeps offering,
		// so the report queue fills and full must stall the input.
		wait_idle();
		load_geometry(CFG_W'(GRID_SIZE), CFG_W'(GRID_SIZE), THR_W'(150));
		hold_requests++;
		add_pixels(FILL_GRID, GRID_SIZE * GRID_SIZE, GRID_SIZE);

		wait_idle();
		if (mismatch_count == 0 && predicted_reports.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
